>>> rtl/periodic_task_tick_scheduler_top_assert.svh
// Assertion macros for the scheduler top level
`ifndef PERIODIC_TASK_TICK_SCHEDULER_TOP_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define PTS_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Implication checked in the cycle after the condition
`define PTS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> rtl/pts_pkg.sv
package pts_pkg;

	typedef enum logic [2:0] {
		K_TICK   = 3'd0,
		K_STATUS = 3'd1,
		K_IVL    = 3'd2,
		K_START  = 3'd3,
		K_PARAM  = 3'd4,
		K_ATTACH = 3'd5,
		K_DETACH = 3'd6,
		K_READ   = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		EV_RUN    = 2'd0,
		EV_EXPIRE = 2'd1,
		EV_DONE   = 2'd2,
		EV_REPLY  = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		RC_OK       = 3'd0,
		RC_BAD_ID   = 3'd1,
		RC_RUNNING  = 3'd2,
		RC_NO_IVL   = 3'd3,
		RC_STARTED  = 3'd4,
		RC_NO_SLOT  = 3'd5,
		RC_NOTFOUND = 3'd6,
		RC_NOTAWAIT = 3'd7
	} reply_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_OUT,
		ST_SCAN_RD,
		ST_SCAN_EX,
		ST_DONE
	} state_t;

	// One result transaction
	typedef struct packed {
		logic [1:0]         ev;
		logic [4:0]         id;
		logic signed [15:0] param;
		logic [2:0]         code;
		logic signed [15:0] status;
		logic [31:0]        interval;
		logic [31:0]        due;
		logic [4:0]         count;
		logic               last;
	} result_t;

endpackage

>>> rtl/pts_out_reg.sv
// Output register: holds one result until it is taken
module pts_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  pts_pkg::result_t  din,
	output logic              busy,
	input  logic              stall,
	output logic              valid,
	output pts_pkg::result_t  dout
);
	import pts_pkg::*;

	logic    valid_q;
	result_t data_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign busy  = valid_q && stall;
	assign valid = valid_q;
	assign dout  = data_q;
endmodule

>>> rtl/pts_engine.sv
// Sequencer around the task table memory
module pts_engine #(
	parameter int TASK_SLOTS      = 16,
	parameter int FIRST_FREE_SLOT = 4,
	parameter int TIME_WIDTH      = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         kind,
	input  logic [4:0]         task_id,
	input  logic [31:0]        interval_value,
	input  logic signed [15:0] status_value,
	input  logic signed [15:0] param_value,
	input  logic               out_busy,
	output logic               out_load,
	output pts_pkg::result_t   out_data
);
	import pts_pkg::*;

	localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int EW = TIME_WIDTH + 32 + 16 + 16;
	localparam int CW = $clog2(TASK_SLOTS + 1);

	typedef struct packed {
		logic [TIME_WIDTH-1:0] due;
		logic [31:0]           interval;
		logic signed [15:0]    status;
		logic signed [15:0]    param;
	} entry_t;

	// Entry memory with a registered read port
	logic [EW-1:0] mem [TASK_SLOTS];
	logic [EW-1:0] rdata_s1;
	logic          mem_we;
	logic [IW-1:0] mem_addr;
	entry_t        wentry;
	entry_t        rentry;

	// Flag registers: attached, awaiting, written
	logic [TASK_SLOTS-1:0] att_q, awt_q, wr_q;

	state_t state_q, state_d;
	logic [TIME_WIDTH-1:0] now_q, scan_q;
	logic [2:0]            kind_q;
	logic [4:0]            id_q;
	logic [31:0]           ivl_q;
	logic signed [15:0]    stv_q, pv_q;
	logic [IW-1:0]         idx_q;
	logic [CW-1:0]         cnt_q;
	result_t               res_q;
	result_t               reply_d;
	logic [IW-1:0]         slot_sel;
	logic                  slot_found;
	logic [IW-1:0]         cur;
	logic                  due_hit;
	logic [TIME_WIDTH-1:0] diff;
	logic [IW-1:0]         id_ix;
	logic [IW-1:0]         cmd_ix;
	logic                  id_ok;

	assign id_ix = id_q[IW-1:0];
	assign id_ok = ({1'b0, id_q} < 6'(TASK_SLOTS));

	// Free slot search over flag bits
	always_comb begin
		slot_sel   = '0;
		slot_found = 1'b0;
		for (int i = TASK_SLOTS - 2; i >= FIRST_FREE_SLOT; i--) begin
			if (!att_q[i]) begin
				slot_sel   = IW'(i);
				slot_found = 1'b1;
			end
		end
	end

	// Attach works on the free slot, other commands on the addressed one
	assign cmd_ix = (kind_q == K_ATTACH) ? slot_sel : id_ix;
	assign cur    = (state_q == ST_SCAN_EX) ? idx_q : cmd_ix;

	// Unwritten entries read as reset value
	always_comb begin
		rentry = entry_t'(rdata_s1);
		if (!wr_q[cur]) begin
			rentry = '0;
			rentry.param = 16'(cur);
		end
	end

	assign diff    = now_q - rentry.due;
	assign due_hit = (rentry.status > 0) && !awt_q[idx_q] && (diff <= TIME_WIDTH'(1));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= EW'(wentry);
		end
		rdata_s1 <= mem[mem_addr];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (kind == K_TICK) begin
						state_d = ST_SCAN_RD;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ:    state_d = ST_EXEC;
			ST_EXEC:    state_d = ST_OUT;
			ST_OUT:     if (!out_busy) state_d = ST_IDLE;
			ST_SCAN_RD: state_d = ST_SCAN_EX;
			ST_SCAN_EX: begin
				if (!out_busy) begin
					if (idx_q == IW'(TASK_SLOTS - 1)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_DONE:    if (!out_busy) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs and memory port
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_load = 1'b0;
		out_data = res_q;
		mem_we   = 1'b0;
		mem_addr = (state_q == ST_SCAN_RD || state_q == ST_SCAN_EX) ? idx_q : cmd_ix;
		wentry   = rentry;
		case (state_q)
			ST_OUT: out_load = !out_busy;
			ST_SCAN_EX: begin
				if (!out_busy && due_hit) begin
					out_load     = 1'b1;
					out_data     = '0;
					out_data.id  = 5'(idx_q);
					if (att_q[idx_q]) begin
						out_data.ev    = EV_RUN;
						out_data.param = rentry.param;
					end else begin
						out_data.ev  = EV_EXPIRE;
						mem_we       = 1'b1;
						wentry.status = '0;
					end
				end
			end
			ST_DONE: begin
				out_load       = !out_busy;
				out_data       = '0;
				out_data.ev    = EV_DONE;
				out_data.count = 5'(cnt_q);
				out_data.last  = 1'b1;
			end
			ST_EXEC: begin
				if (kind_q != K_ATTACH && id_ok) begin
					case (kind_q)
						K_STATUS: begin
							if (awt_q[id_ix]) begin
								mem_we = 1'b1;
								wentry.status = stv_q;
								if (stv_q > 0) wentry.due = scan_q + TIME_WIDTH'(rentry.interval);
							end
						end
						K_IVL: begin
							mem_we = 1'b1;
							wentry.interval = ivl_q;
							if (!awt_q[id_ix]) begin
								wentry.due = now_q + TIME_WIDTH'(ivl_q) + TIME_WIDTH'(1);
							end
						end
						K_START: begin
							if (!awt_q[id_ix] && rentry.interval != '0 && !(rentry.status > 0)) begin
								mem_we = 1'b1;
								wentry.due    = scan_q + TIME_WIDTH'(rentry.interval);
								wentry.status = 16'sd1;
							end
						end
						K_PARAM: begin
							mem_we = 1'b1;
							wentry.param = pv_q;
						end
						K_DETACH: begin
							if (att_q[id_ix]) begin
								mem_we = 1'b1;
								wentry.status   = '0;
								wentry.interval = '0;
								if (!awt_q[id_ix]) wentry.due = now_q + TIME_WIDTH'(1);
							end
						end
						default: ;
					endcase
				end else if (kind_q == K_ATTACH && slot_found) begin
					mem_we = 1'b1;
					wentry.status = '0;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q   <= '0;
			scan_q  <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			wr_q    <= '0;
			awt_q   <= '0;
			for (int i = 0; i < TASK_SLOTS; i++) att_q[i] <= (i < FIRST_FREE_SLOT);
		end else begin
			state_q <= state_d;
			if (mem_we) wr_q[mem_addr] <= 1'b1;
			if (state_q == ST_IDLE && in_valid && kind == K_TICK) begin
				now_q  <= now_q + TIME_WIDTH'(1);
				scan_q <= now_q + TIME_WIDTH'(1);
				idx_q  <= '0;
				cnt_q  <= '0;
			end
			if (state_q == ST_SCAN_EX && !out_busy) begin
				if (due_hit) begin
					cnt_q <= cnt_q + CW'(1);
					if (att_q[idx_q]) awt_q[idx_q] <= 1'b1;
				end
				if (idx_q != IW'(TASK_SLOTS - 1)) idx_q <= idx_q + IW'(1);
			end
			if (state_q == ST_EXEC) begin
				if (kind_q == K_ATTACH) begin
					if (slot_found) begin
						att_q[slot_sel] <= 1'b1;
						awt_q[slot_sel] <= 1'b0;
					end
				end else if (id_ok) begin
					if (kind_q == K_STATUS) awt_q[id_ix] <= 1'b0;
					if (kind_q == K_DETACH && att_q[id_ix]) begin
						att_q[id_ix] <= 1'b0;
						awt_q[id_ix] <= 1'b0;
					end
				end
			end
		end
	end

	// Reply build
	always_comb begin
		reply_d      = '0;
		reply_d.ev   = EV_REPLY;
		reply_d.last = 1'b1;
		reply_d.id   = id_q;
		if (kind_q == K_ATTACH) begin
			reply_d.id   = slot_found ? 5'(slot_sel) : 5'd0;
			reply_d.code = slot_found ? RC_OK : RC_NO_SLOT;
		end else if (!id_ok) begin
			reply_d.code = RC_BAD_ID;
		end else begin
			case (kind_q)
				K_STATUS: if (!awt_q[id_ix]) reply_d.code = RC_NOTAWAIT;
				K_IVL:    if (awt_q[id_ix]) reply_d.code = RC_RUNNING;
				K_START: begin
					if (awt_q[id_ix]) reply_d.code = RC_RUNNING;
					else if (rentry.interval == '0) reply_d.code = RC_NO_IVL;
					else if (rentry.status > 0) reply_d.code = RC_STARTED;
				end
				K_DETACH: if (!att_q[id_ix]) reply_d.code = RC_NOTFOUND;
				K_READ: begin
					reply_d.param    = rentry.param;
					reply_d.status   = rentry.status;
					reply_d.interval = rentry.interval;
					reply_d.due      = 32'(rentry.due);
				end
				default: ;
			endcase
		end
	end

	// Command capture and reply register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			kind_q <= kind;
			id_q   <= task_id;
			ivl_q  <= interval_value;
			stv_q  <= status_value;
			pv_q   <= param_value;
		end
		if (state_q == ST_EXEC) begin
			res_q <= reply_d;
		end
	end
endmodule

>>> rtl/periodic_task_tick_scheduler_top.sv
// Periodic task scheduler. A tick reads and executes each slot in turn, then
// gives a done result, as each slot is read and written back through the
// single port of the entry memory; a command passes through read, execute and
// output states. Results leave through a one-entry output register and stall
// the scan while held. The table is usable straight after reset.
`include "periodic_task_tick_scheduler_top_assert.svh"
module periodic_task_tick_scheduler_top #(
	parameter int TASK_SLOTS      = 16,
	parameter int FIRST_FREE_SLOT = 4,
	parameter int TIME_WIDTH      = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         kind,
	input  logic [4:0]         task_id,
	input  logic [31:0]        interval_value,
	input  logic signed [15:0] status_value,
	input  logic signed [15:0] param_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         event_res,
	output logic [4:0]         task_id_out,
	output logic signed [15:0] param_out,
	output logic [2:0]         reply_code,
	output logic signed [15:0] status_out,
	output logic [31:0]        interval_out,
	output logic [31:0]        due_time_out,
	output logic [4:0]         run_count,
	output logic               last
);
	import pts_pkg::*;

	logic    busy, load;
	result_t res, dout;

	pts_engine #(
		.TASK_SLOTS(TASK_SLOTS),
		.FIRST_FREE_SLOT(FIRST_FREE_SLOT),
		.TIME_WIDTH(TIME_WIDTH)
	) u_engine (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .task_id(task_id), .interval_value(interval_value),
		.status_value(status_value), .param_value(param_value),
		.out_busy(busy), .out_load(load), .out_data(res)
	);

	pts_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .load(load), .din(res), .busy(busy),
		.stall(out_stall), .valid(out_valid), .dout(dout)
	);

	assign event_res    = dout.ev;
	assign task_id_out  = dout.id;
	assign param_out    = dout.param;
	assign reply_code   = dout.code;
	assign status_out   = dout.status;
	assign interval_out = dout.interval;
	assign due_time_out = dout.due;
	assign run_count    = dout.count;
	assign last         = dout.last;

	`PTS_ASSERT_NEXT(a_no_overwrite, clk, arst_n, out_valid && out_stall, out_valid && $stable(dout), "held result changed")
	`PTS_ASSERT_IMP(a_load_free, clk, arst_n, load, !busy, "result loaded over held one")
	`PTS_ASSERT_IMP(a_cmd_last, clk, arst_n, out_valid && event_res == EV_REPLY, last, "reply without last")
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import pts_pkg::*;

	localparam int SLOTS     = 16;
	localparam int FREE_BASE = 4;
	localparam int RAND_ITEMS = 340;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         kind = K_TICK;
	logic [4:0]         task_id = '0;
	logic [31:0]        interval_value = '0;
	logic signed [15:0] status_value = '0;
	logic signed [15:0] param_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         event_res;
	logic [4:0]         task_id_out;
	logic signed [15:0] param_out;
	logic [2:0]         reply_code;
	logic signed [15:0] status_out;
	logic [31:0]        interval_out;
	logic [31:0]        due_time_out;
	logic [4:0]         run_count;
	logic               last;

	periodic_task_tick_scheduler_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .task_id(task_id), .interval_value(interval_value),
		.status_value(status_value), .param_value(param_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_res(event_res), .task_id_out(task_id_out), .param_out(param_out),
		.reply_code(reply_code), .status_out(status_out), .interval_out(interval_out),
		.due_time_out(due_time_out), .run_count(run_count), .last(last)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Scheduler shadow state
	logic [31:0]        sch_now, sch_scan;
	logic signed [15:0] slot_status [SLOTS];
	logic [31:0]        slot_ivl [SLOTS];
	logic [31:0]        slot_due [SLOTS];
	logic signed [15:0] slot_param [SLOTS];
	bit                 slot_att [SLOTS];
	bit                 slot_wait [SLOTS];

	result_t sched_q[$];
	int      err_count = 0;

	typedef struct {
		kind_t              k;
		logic [4:0]         id;
		logic [31:0]        ivl;
		logic signed [15:0] st;
		logic signed [15:0] pv;
		bit                 typed;
		result_t            res;
	} stim_row_t;

	stim_row_t dir_tab[$];

	function automatic result_t mk_reply(logic [4:0] id, reply_t c);
		result_t r;
		r = '0;
		r.ev = EV_REPLY;
		r.id = id;
		r.code = c;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void add_row(kind_t k, logic [4:0] id, logic [31:0] ivl,
			logic signed [15:0] st, logic signed [15:0] pv, bit typed, result_t res);
		stim_row_t r;
		r.k = k; r.id = id; r.ivl = ivl; r.st = st; r.pv = pv;
		r.typed = typed; r.res = res;
		dir_tab.push_back(r);
	endfunction

	function automatic void push_res(event_t ev, logic [4:0] id, logic signed [15:0] prm,
			reply_t c, logic signed [15:0] st, logic [31:0] ivl, logic [31:0] due,
			logic [4:0] cnt, logic lst);
		result_t r;
		r.ev = ev; r.id = id; r.param = prm; r.code = c; r.status = st;
		r.interval = ivl; r.due = due; r.count = cnt; r.last = lst;
		sched_q.push_back(r);
	endfunction

	function automatic void sched_reset();
		sch_now = '0;
		sch_scan = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_status[i] = '0;
			slot_ivl[i] = '0;
			slot_due[i] = '0;
			slot_param[i] = 16'(i);
			slot_att[i] = (i < FREE_BASE);
			slot_wait[i] = 1'b0;
		end
	endfunction

	// Work out the results of one accepted transaction
	function automatic void sched_predict(kind_t k, logic [4:0] id, logic [31:0] ivl,
			logic signed [15:0] st, logic signed [15:0] pv);
		logic [4:0]  cnt;
		logic [31:0] diff;
		reply_t      c;
		bit          found;
		cnt = '0;
		c = RC_OK;
		found = 1'b0;
		if (k == K_TICK) begin
			sch_now = sch_now + 1;
			sch_scan = sch_now;
			for (int i = 0; i < SLOTS; i++) begin
				diff = sch_now - slot_due[i];
				if (slot_status[i] > 0 && !slot_wait[i] && diff <= 32'd1) begin
					if (slot_att[i]) begin
						slot_wait[i] = 1'b1;
						push_res(EV_RUN, 5'(i), slot_param[i], RC_OK, 0, 0, 0, 0, 0);
					end else begin
						slot_status[i] = '0;
						push_res(EV_EXPIRE, 5'(i), 0, RC_OK, 0, 0, 0, 0, 0);
					end
					cnt++;
				end
			end
			push_res(EV_DONE, 0, 0, RC_OK, 0, 0, 0, cnt, 1);
		end else if (k == K_ATTACH) begin
			for (int i = FREE_BASE; i < SLOTS - 1; i++) begin
				if (!found && !slot_att[i]) begin
					found = 1'b1;
					slot_att[i] = 1'b1;
					slot_status[i] = '0;
					slot_wait[i] = 1'b0;
					push_res(EV_REPLY, 5'(i), 0, RC_OK, 0, 0, 0, 0, 1);
				end
			end
			if (!found)
				push_res(EV_REPLY, 0, 0, RC_NO_SLOT, 0, 0, 0, 0, 1);
		end else if (id >= SLOTS) begin
			push_res(EV_REPLY, id, 0, RC_BAD_ID, 0, 0, 0, 0, 1);
		end else if (k == K_READ) begin
			push_res(EV_REPLY, id, slot_param[id], RC_OK, slot_status[id], slot_ivl[id],
				slot_due[id], 0, 1);
		end else begin
			case (k)
				K_STATUS: begin
					if (!slot_wait[id]) begin
						c = RC_NOTAWAIT;
					end else begin
						slot_status[id] = st;
						if (st > 0)
							slot_due[id] = sch_scan + slot_ivl[id];
						slot_wait[id] = 1'b0;
					end
				end
				K_IVL: begin
					slot_ivl[id] = ivl;
					if (slot_wait[id])
						c = RC_RUNNING;
					else
						slot_due[id] = sch_now + ivl + 1;
				end
				K_START: begin
					if (slot_wait[id]) begin
						c = RC_RUNNING;
					end else if (slot_ivl[id] == 0) begin
						c = RC_NO_IVL;
					end else if (slot_status[id] > 0) begin
						c = RC_STARTED;
					end else begin
						slot_due[id] = sch_scan + slot_ivl[id];
						slot_status[id] = 16'sd1;
					end
				end
				K_PARAM: slot_param[id] = pv;
				default: begin
					// detach
					if (!slot_att[id]) begin
						c = RC_NOTFOUND;
					end else begin
						slot_att[id] = 1'b0;
						slot_status[id] = '0;
						slot_ivl[id] = '0;
						if (!slot_wait[id])
							slot_due[id] = sch_now + 1;
						slot_wait[id] = 1'b0;
					end
				end
			endcase
			push_res(EV_REPLY, id, 0, c, 0, 0, 0, 0, 1);
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		err_count++;
	endtask

	// Result checker
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (sched_q.size() == 0) begin
				report_mismatch("unexpected result", {27'd0, task_id_out}, 32'd0);
			end else begin
				e = sched_q.pop_front();
				if (event_res !== e.ev) report_mismatch("event", event_res, e.ev);
				if (task_id_out !== e.id) report_mismatch("task id", task_id_out, e.id);
				if (param_out !== e.param) report_mismatch("param", param_out, e.param);
				if (reply_code !== e.code) report_mismatch("reply", reply_code, e.code);
				if (status_out !== e.status) report_mismatch("status", status_out, e.status);
				if (interval_out !== e.interval)
					report_mismatch("interval", interval_out, e.interval);
				if (due_time_out !== e.due) report_mismatch("due time", due_time_out, e.due);
				if (run_count !== e.count) report_mismatch("run count", run_count, e.count);
				if (last !== e.last) report_mismatch("last", last, e.last);
			end
		end
	end

	// Receiver stall pattern: one of four modes, redrawn at random
	int stall_mode = 0;
	int stall_cyc = 0;
	always @(negedge clk) begin
		if (stall_cyc % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		stall_cyc++;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((stall_cyc / 5) % 2 == 1);
		endcase
	end

	// Sender: bursts with random gaps
	int burst_left = 0;

	task automatic send_item(kind_t k, logic [4:0] id, logic [31:0] ivl,
			logic signed [15:0] st, logic signed [15:0] pv);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		task_id <= id;
		interval_value <= ivl;
		status_value <= st;
		param_value <= pv;
		do @(posedge clk); while (in_stall);
		sched_predict(k, id, ivl, st, pv);
	endtask

	function automatic logic [31:0] rand_interval();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF;
			2: return 32'd0;
			default: return $urandom_range(1, 5);
		endcase
	endfunction

	function automatic logic [4:0] rand_slot();
		if ($urandom_range(0, 9) == 0)
			return 5'($urandom_range(16, 31));
		return 5'($urandom_range(0, SLOTS - 1));
	endfunction

	// Pick the next random transaction, mostly well-formed task traffic
	task automatic send_random();
		int          sel;
		int          waiting[$];
		logic [4:0]  id;
		logic signed [15:0] st;
		for (int i = 0; i < SLOTS; i++)
			if (slot_wait[i]) waiting.push_back(i);
		sel = $urandom_range(0, 99);
		id = rand_slot();
		if (sel < 35) begin
			send_item(K_TICK, id, $urandom(), 16'($urandom()), 16'($urandom()));
		end else if (sel < 55) begin
			if (waiting.size() > 0 && $urandom_range(0, 7) != 0)
				id = 5'(waiting[$urandom_range(0, waiting.size() - 1)]);
			st = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 3));
			send_item(K_STATUS, id, $urandom(), st, 16'($urandom()));
		end else if (sel < 67) begin
			send_item(K_IVL, id, rand_interval(), 16'($urandom()), 16'($urandom()));
		end else if (sel < 79) begin
			send_item(K_START, id, $urandom(), 16'($urandom()), 16'($urandom()));
		end else if (sel < 84) begin
			send_item(K_PARAM, id, $urandom(), 16'($urandom()), 16'($urandom()));
		end else if (sel < 89) begin
			send_item(K_ATTACH, 5'($urandom()), $urandom(), 16'($urandom()),
				16'($urandom()));
		end else if (sel < 94) begin
			send_item(K_DETACH, id, $urandom(), 16'($urandom()), 16'($urandom()));
		end else begin
			send_item(K_READ, id, $urandom(), 16'($urandom()), 16'($urandom()));
		end
	endtask

	initial begin
		stim_row_t r;
		sched_reset();
		// directed table
		add_row(K_READ,   0,  0, 0, 0, 1, mk_reply(0, RC_OK));
		add_row(K_READ,   31, 0, 0, 0, 1, mk_reply(31, RC_BAD_ID));
		add_row(K_DETACH, 16, 0, 0, 0, 1, mk_reply(16, RC_BAD_ID));
		add_row(K_STATUS, 1,  0, 5, 0, 1, mk_reply(1, RC_NOTAWAIT));
		add_row(K_START,  2,  0, 0, 0, 1, mk_reply(2, RC_NO_IVL));
		add_row(K_DETACH, 10, 0, 0, 0, 1, mk_reply(10, RC_NOTFOUND));
		add_row(K_ATTACH, 31, 0, 0, 0, 1, mk_reply(4, RC_OK));
		add_row(K_IVL,    0,  1, 0, 0, 1, mk_reply(0, RC_OK));
		add_row(K_START,  0,  0, 0, 0, 1, mk_reply(0, RC_OK));
		add_row(K_START,  0,  0, 0, 0, 1, mk_reply(0, RC_STARTED));
		add_row(K_PARAM,  0,  0, 0, -16'sd32768, 1, mk_reply(0, RC_OK));
		add_row(K_TICK,   0,  0, 0, 0, 0, '0);
		add_row(K_IVL,    0,  32'hFFFF_FFFF, 0, 0, 1, mk_reply(0, RC_RUNNING));
		add_row(K_START,  0,  0, 0, 0, 1, mk_reply(0, RC_RUNNING));
		add_row(K_PARAM,  0,  0, 0, 16'sd32767, 1, mk_reply(0, RC_OK));
		add_row(K_READ,   0,  0, 0, 0, 0, '0);
		add_row(K_STATUS, 0,  0, 16'sd32767, 0, 1, mk_reply(0, RC_OK));
		add_row(K_READ,   0,  0, 0, 0, 0, '0);
		add_row(K_IVL,    5,  2, 0, 0, 1, mk_reply(5, RC_OK));
		add_row(K_START,  5,  0, 0, 0, 1, mk_reply(5, RC_OK));
		add_row(K_TICK,   0,  0, 0, 0, 0, '0);
		add_row(K_TICK,   0,  0, 0, 0, 0, '0);
		add_row(K_TICK,   0,  0, 0, 0, 0, '0);
		add_row(K_DETACH, 4,  0, 0, 0, 1, mk_reply(4, RC_OK));
		add_row(K_STATUS, 0,  0, -16'sd32768, 0, 1, mk_reply(0, RC_NOTAWAIT));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			r = dir_tab[i];
			send_item(r.k, r.id, r.ivl, r.st, r.pv);
			// typed rows replace the prediction just made
			if (r.typed) begin
				void'(sched_q.pop_back());
				sched_q.push_back(r.res);
			end
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 2) begin
				// hold off until the block has drained
				@(negedge clk);
				in_valid <= 1'b0;
				while (sched_q.size() != 0) @(posedge clk);
				burst_left = 0;
			end
			send_random();
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (sched_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (err_count == 0 && sched_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Run limit
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

>>> periodic_task_tick_scheduler_top.f
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_out_reg.sv
rtl/pts_engine.sv
rtl/periodic_task_tick_scheduler_top.sv
tb/tb_top.sv
